>>> hw/rtl/uart_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_pkg
// Shared types, register indexes and field widths for the serial transceiver.
// ----------------------------------------------------------------------------
package uart_pkg;

  localparam int BYTE_W       = 8;
  localparam int TICKS_W      = 16;
  localparam int S_TDATA_W    = 16;
  localparam int M_TDATA_W    = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int DATA_BITS_DEF   = 8;
  localparam int TIMER_WIDTH_DEF = 16;

  localparam logic [TICKS_W-1:0] BIT_TICKS_RST = 16'd104;

  // register indexes on the config channel
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PARITY    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TWO_STOP  = 2'd2;

  // parity mode codes
  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_ODD  = 2'd1;
  localparam logic [1:0] PAR_EVEN = 2'd2;

  typedef struct packed {
    logic [1:0] parity_mode;
    logic       two_stop;
  } frame_cfg_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_result_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } rx_result_t;

  function automatic logic parity_on(input logic [1:0] mode);
    return (mode == PAR_ODD) || (mode == PAR_EVEN);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/uart_tx.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_tx
// Transmit framer: start bit, data bits LSB first, optional parity, stop bits.
// ----------------------------------------------------------------------------
module uart_tx
  import uart_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int PW        = TICKS_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              cmd,
  input  logic [BYTE_W-1:0] tx_byte,
  input  logic [PW-1:0]     period,
  input  frame_cfg_t        fcfg,
  output tx_result_t        res
);

  localparam int IW = $clog2(DATA_BITS + 1);

  typedef enum logic [2:0] {
    TX_IDLE,
    TX_START,
    TX_DATA,
    TX_PARITY,
    TX_STOP1,
    TX_STOP2
  } tx_phase_t;

  tx_phase_t            phase, phase_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic                 parity_acc, parity_acc_next;
  logic [IW-1:0]        bit_index, bit_index_next;
  logic [PW-1:0]        timer, timer_next;
  logic [PW-1:0]        timer_dec;
  logic [BYTE_W+DATA_BITS-1:0] byte_ext;

  assign byte_ext  = {{DATA_BITS{1'b0}}, tx_byte};
  assign timer_dec = timer - PW'(timer != '0);

  always_comb begin
    phase_next      = phase;
    shift_next      = shift;
    parity_acc_next = parity_acc;
    bit_index_next  = bit_index;
    timer_next      = timer;

    if (phase != TX_IDLE) begin
      timer_next = timer_dec;
      if (timer_dec == '0) begin
        case (phase)
          TX_START: begin
            phase_next     = TX_DATA;
            bit_index_next = '0;
          end
          TX_DATA: begin
            // data goes out of bit 0, the shifter moves down one per bit
            parity_acc_next = parity_acc ^ shift[0];
            shift_next      = shift >> 1;
            bit_index_next  = bit_index + IW'(1);
            if (bit_index_next >= IW'(DATA_BITS)) begin
              phase_next = parity_on(fcfg.parity_mode) ? TX_PARITY : TX_STOP1;
            end
          end
          TX_PARITY: phase_next = TX_STOP1;
          TX_STOP1:  phase_next = fcfg.two_stop ? TX_STOP2 : TX_IDLE;
          default:   phase_next = TX_IDLE;
        endcase
        timer_next = (phase_next == TX_IDLE) ? '0 : period;
      end
    end

    // idle at the end of a stop bit still takes a request on this tick
    if (phase_next == TX_IDLE && cmd) begin
      shift_next      = byte_ext[DATA_BITS-1:0];
      parity_acc_next = 1'b0;
      bit_index_next  = '0;
      phase_next      = TX_START;
      timer_next      = period;
    end
  end

  always_comb begin
    case (phase_next)
      TX_START:  res.line = 1'b0;
      TX_DATA:   res.line = shift_next[0];
      TX_PARITY: res.line = (fcfg.parity_mode == PAR_ODD) ? ~parity_acc_next
                                                          : parity_acc_next;
      default:   res.line = 1'b1;
    endcase
    res.busy = (phase_next != TX_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= TX_IDLE;
      shift      <= '0;
      parity_acc <= 1'b0;
      bit_index  <= '0;
      timer      <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      shift      <= shift_next;
      parity_acc <= parity_acc_next;
      bit_index  <= bit_index_next;
      timer      <= timer_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/uart_rx.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rx
// Receive sampler: start detect, mid-bit sampling, tail wait, byte report.
// ----------------------------------------------------------------------------
module uart_rx
  import uart_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int PW        = TICKS_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          rx_line,
  input  logic [PW-1:0] period,
  input  frame_cfg_t    fcfg,
  output rx_result_t    res
);

  localparam int IW = $clog2(DATA_BITS + 1);
  localparam int RW = PW + 1;

  typedef enum logic [1:0] {
    RX_HUNT,
    RX_START,
    RX_DATA,
    RX_TAIL
  } rx_phase_t;

  rx_phase_t            phase, phase_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [DATA_BITS-1:0] hold, hold_next;
  logic [IW-1:0]        bit_index, bit_index_next;
  logic [RW-1:0]        timer, timer_next;
  logic [RW-1:0]        timer_dec;
  logic [RW-1:0]        period_ext;
  logic                 valid_next;
  logic [BYTE_W+DATA_BITS-1:0] hold_ext;

  assign period_ext = {1'b0, period};
  assign timer_dec  = timer - RW'(timer != '0);
  assign hold_ext   = {{BYTE_W{1'b0}}, hold_next};

  always_comb begin
    phase_next     = phase;
    shift_next     = shift;
    hold_next      = hold;
    bit_index_next = bit_index;
    timer_next     = timer;
    valid_next     = 1'b0;

    if (phase == RX_HUNT) begin
      if (!rx_line) begin
        // first sample lands in the middle of bit 0
        phase_next     = RX_START;
        timer_next     = period_ext + (period_ext >> 1);
        bit_index_next = '0;
      end
    end else begin
      timer_next = timer_dec;
      if (timer_dec == '0) begin
        if (phase == RX_START || phase == RX_DATA) begin
          // LSB arrives first and ends at bit 0 after all samples
          shift_next     = {rx_line, shift[DATA_BITS-1:1]};
          bit_index_next = bit_index + IW'(1);
          phase_next     = RX_DATA;
          if (bit_index_next >= IW'(DATA_BITS)) begin
            phase_next     = RX_TAIL;
            bit_index_next = IW'(1) + IW'(parity_on(fcfg.parity_mode))
                           + IW'(fcfg.two_stop);
          end
          timer_next = period_ext;
        end else begin
          bit_index_next = bit_index - IW'(bit_index != '0);
          if (bit_index_next == '0) begin
            hold_next  = shift;
            valid_next = 1'b1;
            phase_next = RX_HUNT;
            timer_next = '0;
          end else begin
            timer_next = period_ext;
          end
        end
      end
    end
  end

  assign res.valid = valid_next;
  assign res.data  = hold_ext[BYTE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= RX_HUNT;
      shift     <= '0;
      hold      <= '0;
      bit_index <= '0;
      timer     <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      shift     <= shift_next;
      hold      <= hold_next;
      bit_index <= bit_index_next;
      timer     <= timer_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/uart_transmitter_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_transmitter_receiver_unit
// Tick-driven serial transceiver with optional parity and one or two stop bits.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on s_axis is one timebase tick: tuser carries the send
//   request, tdata the byte to send and the sampled receive line. Every input
//   beat yields exactly one output beat on m_axis with the transmit line level,
//   the busy flag, the receive strobe and the last received byte.
//   The single output register after the per-tick logic makes the output beat
//   appear in the cycle after its input beat; one beat per cycle unless stalled.
//   s_axis_tready drops only while a result sits in the output register and
//   m_axis_tready is low, so a stalled consumer holds off the next tick and
//   no result is lost.
//   The cfg channel is always ready; index 0 bit_ticks, 1 parity_mode,
//   2 two_stop. Write it only while no tick is in flight.
//   Reset (rst, synchronous) returns 104 ticks per bit, no parity, one stop
//   bit, an idle transmitter, a receiver hunting for a start bit and a held
//   received byte of zero. There is no clearing pass.
// ----------------------------------------------------------------------------
module uart_transmitter_receiver_unit
  import uart_pkg::*;
#(
  parameter int DATA_BITS   = DATA_BITS_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] tx_byte, [8] rx_line
  input  logic                   s_axis_tuser,   // [0] cmd
  // master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [0] tx_line, [1] tx_busy,
                                                 // [2] rx_valid, [10:3] rx_byte
  // config writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = (TIMER_WIDTH < TICKS_W) ? TIMER_WIDTH : TICKS_W;

  logic [TICKS_W-1:0] bit_ticks;
  frame_cfg_t         fcfg;
  logic [PW-1:0]      period;
  logic               accept;
  tx_result_t         tx_res;
  rx_result_t         rx_res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // a zero bit time runs as one tick
  assign period = (bit_ticks[PW-1:0] == '0) ? PW'(1) : bit_ticks[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks        <= BIT_TICKS_RST;
      fcfg.parity_mode <= PAR_NONE;
      fcfg.two_stop    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_TICKS: bit_ticks        <= cfg_data[TICKS_W-1:0];
        REG_PARITY:    fcfg.parity_mode <= cfg_data[1:0];
        REG_TWO_STOP:  fcfg.two_stop    <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  uart_tx #(
    .DATA_BITS (DATA_BITS),
    .PW        (PW)
  ) u_tx (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .cmd     (s_axis_tuser),
    .tx_byte (s_axis_tdata[BYTE_W-1:0]),
    .period  (period),
    .fcfg    (fcfg),
    .res     (tx_res)
  );

  uart_rx #(
    .DATA_BITS (DATA_BITS),
    .PW        (PW)
  ) u_rx (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .rx_line (s_axis_tdata[BYTE_W]),
    .period  (period),
    .fcfg    (fcfg),
    .res     (rx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= M_TDATA_W'({rx_res.data, rx_res.valid, tx_res.busy, tx_res.line});
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: serial transceiver regression
// Streams timebase ticks into the transceiver with send requests and receive
// line levels made from clean, broken and noisy serial frames. A cycle-level
// software copy of the transmitter and receiver predicts every output beat;
// the checker compares each beat field by field. Frame settings are changed
// between test phases, with random gaps on both stream sides and one long
// consumer stall.
// ----------------------------------------------------------------------------
module tb_top;
  import uart_pkg::*;

  localparam int  HOLD_CYCLES = 300;
  localparam int  GAP_PCT     = 31;
  localparam time LIMIT_NS    = 2_000_000;

  typedef enum logic [2:0] {
    TX_IDLE, TX_START, TX_DATA, TX_PARITY, TX_STOP1, TX_STOP2
  } tx_state_e;

  typedef enum logic [1:0] {RX_HUNT, RX_START, RX_DATA, RX_TAIL} rx_state_e;

  typedef struct packed {
    logic        tx_line;
    logic        tx_busy;
    logic        rx_valid;
    logic [7:0]  rx_byte;
  } tick_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  uart_transmitter_receiver_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predicted transceiver state and its registers
  logic [TICKS_W-1:0] cfg_bit_ticks;
  logic [1:0]         cfg_parity;
  logic               cfg_two_stop;

  tx_state_e   tx_state;
  logic [7:0]  tx_shift;
  logic        tx_parity_acc;
  logic [3:0]  tx_index;
  logic [16:0] tx_timer;
  rx_state_e   rx_state;
  logic [7:0]  rx_shift;
  logic [3:0]  rx_index;
  logic [16:0] rx_timer;
  logic [7:0]  rx_held;

  tick_result_t pending_results [$];
  tick_result_t want;
  logic         rx_pending [$];
  logic         last_tx_line;
  logic         rx_autofill;
  logic         loopback;
  logic         no_gaps;
  logic         hold_request;
  int           mismatch_count;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [16:0] bit_period();
    return (cfg_bit_ticks == '0) ? 17'd1 : {1'b0, cfg_bit_ticks};
  endfunction

  function automatic logic parity_bit_on();
    return (cfg_parity == PAR_ODD) || (cfg_parity == PAR_EVEN);
  endfunction

  // one tick of the transceiver; queues the beat it should produce
  function automatic void advance_uart(input logic req, input logic [7:0] data,
                                       input logic line);
    tick_result_t r;
    logic [16:0]  t;
    logic         done;
    t = bit_period();
    done = 1'b0;

    if (tx_state != TX_IDLE) begin
      if (tx_timer != '0) tx_timer = tx_timer - 17'd1;
      if (tx_timer == '0) begin
        case (tx_state)
          TX_START: begin
            tx_state = TX_DATA;
            tx_index = 4'd0;
          end
          TX_DATA: begin
            tx_parity_acc = tx_parity_acc ^ tx_shift[tx_index[2:0]];
            tx_index = tx_index + 4'd1;
            if (tx_index >= 4'd8) tx_state = parity_bit_on() ? TX_PARITY : TX_STOP1;
          end
          TX_PARITY: tx_state = TX_STOP1;
          TX_STOP1:  tx_state = cfg_two_stop ? TX_STOP2 : TX_IDLE;
          default:   tx_state = TX_IDLE;
        endcase
        tx_timer = (tx_state == TX_IDLE) ? 17'd0 : t;
      end
    end
    // back to back: a request is taken on the tick the last stop bit ends
    if (tx_state == TX_IDLE && req) begin
      tx_shift      = data;
      tx_parity_acc = 1'b0;
      tx_index      = 4'd0;
      tx_state      = TX_START;
      tx_timer      = t;
    end

    if (rx_state == RX_HUNT) begin
      if (!line) begin
        rx_state = RX_START;
        rx_timer = t + (t >> 1);
        rx_index = 4'd0;
        rx_shift = 8'd0;
      end
    end else begin
      if (rx_timer != '0) rx_timer = rx_timer - 17'd1;
      if (rx_timer == '0) begin
        if (rx_state == RX_START || rx_state == RX_DATA) begin
          if (line) rx_shift[rx_index[2:0]] = 1'b1;
          rx_index = rx_index + 4'd1;
          rx_state = RX_DATA;
          if (rx_index >= 4'd8) begin
            rx_state = RX_TAIL;
            rx_index = 4'd1 + 4'(parity_bit_on()) + 4'(cfg_two_stop);
          end
          rx_timer = t;
        end else begin
          if (rx_index != '0) rx_index = rx_index - 4'd1;
          if (rx_index == '0) begin
            rx_held  = rx_shift;
            done     = 1'b1;
            rx_state = RX_HUNT;
            rx_timer = 17'd0;
          end else begin
            rx_timer = t;
          end
        end
      end
    end

    case (tx_state)
      TX_START:  r.tx_line = 1'b0;
      TX_DATA:   r.tx_line = tx_shift[tx_index[2:0]];
      TX_PARITY: r.tx_line = (cfg_parity == PAR_ODD) ? ~tx_parity_acc : tx_parity_acc;
      default:   r.tx_line = 1'b1;
    endcase
    r.tx_busy  = (tx_state != TX_IDLE);
    r.rx_valid = done;
    r.rx_byte  = rx_held;
    pending_results.push_back(r);
    last_tx_line = r.tx_line;
  endfunction

  // serial levels for one frame at the current settings, cut after 'slots' bits
  function automatic void queue_frame(input logic [7:0] data, input int slots);
    logic [11:0] lv;
    int          nb;
    lv = '1;
    lv[0] = 1'b0;
    lv[8:1] = data;
    nb = 10;
    if (parity_bit_on()) begin
      lv[9] = (cfg_parity == PAR_ODD) ? ~^data : ^data;
      nb = 11;
    end
    if (cfg_two_stop) nb = nb + 1;
    for (int k = 0; k < nb && k < slots; k++)
      repeat (bit_period()) rx_pending.push_back(lv[k]);
  endfunction

  function automatic void refill_rx();
    int pick;
    int bt;
    bt = int'(bit_period());
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      queue_frame(8'($urandom_range(0, 255)), 12);
      repeat ($urandom_range(0, 2 * bt)) rx_pending.push_back(1'b1);
    end else if (pick < 78) begin
      // broken frame: line returns high early
      queue_frame(8'($urandom_range(0, 255)), $urandom_range(1, 8));
      repeat ($urandom_range(1, 3 * bt)) rx_pending.push_back(1'b1);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 8)) rx_pending.push_back(1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 4 * bt)) rx_pending.push_back(1'b1);
    end
  endfunction

  function automatic logic next_rx_level();
    if (rx_pending.size() == 0 && rx_autofill) refill_rx();
    if (rx_pending.size() == 0) return 1'b1;
    return rx_pending.pop_front();
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  // one tick beat; returns at the rising edge that took it
  task automatic send_tick(input logic req, input logic [7:0] data, input logic line);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {{(S_TDATA_W - 9){1'b0}}, line, data};
    do @(posedge clk); while (!s_axis_tready);
    advance_uart(req, data, line);
  endtask

  task automatic run_ticks(input int n, input int req_pct);
    logic line;
    repeat (n) begin
      line = loopback ? last_tx_line : next_rx_level();
      send_tick($urandom_range(0, 99) < req_pct, 8'($urandom_range(0, 255)), line);
    end
  endtask

  // no tick in flight and every beat back
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BIT_TICKS: cfg_bit_ticks = value[TICKS_W-1:0];
      REG_PARITY:    cfg_parity    = value[1:0];
      REG_TWO_STOP:  cfg_two_stop  = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [15:0] ticks, input logic [1:0] par,
                           input logic two);
    settle();
    write_reg(REG_BIT_TICKS, ticks);
    write_reg(REG_PARITY, {14'd0, par});
    write_reg(REG_TWO_STOP, {15'd0, two});
  endtask

  task automatic test_reset_state();
    repeat (4) send_tick(1'b0, 8'h00, 1'b1);
  endtask

  // zero bit time acts as one; requests while busy and back to back frames
  task automatic test_min_bit_time();
    set_frame(16'd0, PAR_NONE, 1'b0);
    queue_frame(8'hA5, 12);
    for (int k = 0; k < 14; k++) send_tick(1'b1, (k % 2) ? 8'hFF : 8'h00, next_rx_level());
    set_frame(16'd1, PAR_ODD, 1'b1);
    queue_frame(8'h00, 12);
    queue_frame(8'hFF, 12);
    for (int k = 0; k < 28; k++) send_tick(1'b1, (k < 14) ? 8'hFF : 8'h00, next_rx_level());
  endtask

  // settings change while frames are on the wire; unused parity code
  task automatic test_mid_frame_change();
    set_frame(16'd3, PAR_EVEN, 1'b0);
    queue_frame(8'h3C, 12);
    send_tick(1'b1, 8'hC3, next_rx_level());
    run_ticks(8, 0);
    set_frame(16'd2, 2'd3, 1'b1);
    run_ticks(40, 0);
    queue_frame(8'h96, 12);
    run_ticks(30, 50);
  endtask

  task automatic test_random_traffic();
    rx_autofill = 1'b1;
    for (int ph = 0; ph < 9; ph++) begin
      set_frame(16'($urandom_range(1, 6)), 2'(($urandom_range(0, 9) == 0) ? 2'd3 :
                $urandom_range(0, 2)), 1'($urandom_range(0, 1)));
      no_gaps  = (ph == 0);
      loopback = ph[0];
      run_ticks(140, 20);
    end
    no_gaps  = 1'b0;
    loopback = 1'b0;
  endtask

  // consumer holds off while ticks keep coming, so the input backs up
  task automatic test_consumer_stall();
    set_frame(16'd2, PAR_NONE, 1'b0);
    hold_request = 1'b1;
    run_ticks(60, 25);
  endtask

  // largest bit time: start bit and receive timers stretch far past a short run
  task automatic test_long_bit_time();
    set_frame(16'hFFFF, PAR_EVEN, 1'b1);
    rx_autofill = 1'b0;
    rx_pending.delete();
    repeat (40) rx_pending.push_back(1'b0);
    send_tick(1'b1, 8'hFF, next_rx_level());
    run_ticks(60, 50);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 16'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.tx_line)
          report_mismatch("tx_line", 16'(m_axis_tdata[0]), 16'(want.tx_line));
        if (m_axis_tdata[1] !== want.tx_busy)
          report_mismatch("tx_busy", 16'(m_axis_tdata[1]), 16'(want.tx_busy));
        if (m_axis_tdata[2] !== want.rx_valid)
          report_mismatch("rx_valid", 16'(m_axis_tdata[2]), 16'(want.rx_valid));
        if (m_axis_tdata[10:3] !== want.rx_byte)
          report_mismatch("rx_byte", 16'(m_axis_tdata[10:3]), 16'(want.rx_byte));
      end
    end
  end

  initial begin : consumer_ready
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("uart_transmitter_receiver_unit regression: fail");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cfg_bit_ticks = BIT_TICKS_RST;
    cfg_parity    = PAR_NONE;
    cfg_two_stop  = 1'b0;
    tx_state      = TX_IDLE;
    tx_shift      = 8'd0;
    tx_parity_acc = 1'b0;
    tx_index      = 4'd0;
    tx_timer      = 17'd0;
    rx_state      = RX_HUNT;
    rx_shift      = 8'd0;
    rx_index      = 4'd0;
    rx_timer      = 17'd0;
    rx_held       = 8'd0;
    last_tx_line  = 1'b1;
    rx_autofill   = 1'b0;
    loopback      = 1'b0;
    no_gaps       = 1'b0;
    hold_request  = 1'b0;
    mismatch_count = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_min_bit_time();
    test_mid_frame_change();
    test_random_traffic();
    test_consumer_stall();
    test_long_bit_time();

    settle();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0)
      $display("uart_transmitter_receiver_unit regression: pass");
    else
      $display("uart_transmitter_receiver_unit regression: fail");
    $finish;
  end

endmodule
